FILE: rtl/assert_macros.svh
// assertion macros used by the deframer rtl
// no dependencies; included by modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("property violated");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

FILE: rtl/hlfd_pkg.sv
// types and constants of the header/length frame deframer
// no dependencies
package hlfd_pkg;

    localparam int POS_W   = 5;
    localparam int LEN_W   = 16;
    localparam int BYTE_W  = 8;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;
    localparam int POS_MAX = 32;

    localparam logic [POS_W-1:0] LEN_LOW_POS  = 5'd6;
    localparam logic [POS_W-1:0] LEN_HIGH_POS = 5'd7;

    localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'hAA;
    localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'h55;
    localparam logic [LEN_W-1:0]  LENGTH_LIMIT_RST  = 16'd50;
    localparam logic [POS_W-1:0]  POSITION_CAP_RST  = 5'd26;

    typedef enum logic [1:0] {
        REG_HEADER_FIRST  = 2'd0,
        REG_HEADER_SECOND = 2'd1,
        REG_LENGTH_LIMIT  = 2'd2,
        REG_POSITION_CAP  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [BYTE_W-1:0] header_first;
        logic [BYTE_W-1:0] header_second;
        logic [LEN_W-1:0]  length_limit;
        logic [POS_W-1:0]  position_cap;
    } cfg_t;

    typedef struct packed {
        logic wr_en;
        logic shift_en;
    } cell_ctrl_t;

endpackage

FILE: rtl/hlfd_cell.sv
// one byte cell of the frame store chain
// depends on hlfd_pkg
module hlfd_cell (
    input  logic                       aclk,
    input  hlfd_pkg::cell_ctrl_t       ctrl,
    input  logic [hlfd_pkg::BYTE_W-1:0] wr_data,
    input  logic [hlfd_pkg::BYTE_W-1:0] shift_in,
    output logic [hlfd_pkg::BYTE_W-1:0] data
);

    logic [hlfd_pkg::BYTE_W-1:0] data_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            data_reg <= wr_data;
        end else if (ctrl.shift_en) begin
            data_reg <= shift_in;
        end
    end

    assign data = data_reg;

endmodule

FILE: rtl/hlfd_cfg.sv
// apb register file of the deframer
// depends on hlfd_pkg
module hlfd_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hlfd_pkg::ADDR_W-1:0] paddr,
    input  logic [hlfd_pkg::DATA_W-1:0] pwdata,
    output logic [hlfd_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output hlfd_pkg::cfg_t              cfg
);

    hlfd_pkg::cfg_t     cfg_reg;
    hlfd_pkg::reg_idx_t reg_idx;
    logic               wr_en;

    assign pready  = 1'b1;
    assign reg_idx = hlfd_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_first  <= hlfd_pkg::HEADER_FIRST_RST;
            cfg_reg.header_second <= hlfd_pkg::HEADER_SECOND_RST;
            cfg_reg.length_limit  <= hlfd_pkg::LENGTH_LIMIT_RST;
            cfg_reg.position_cap  <= hlfd_pkg::POSITION_CAP_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                hlfd_pkg::REG_HEADER_FIRST: begin
                    cfg_reg.header_first <= pwdata[hlfd_pkg::BYTE_W-1:0];
                end
                hlfd_pkg::REG_HEADER_SECOND: begin
                    cfg_reg.header_second <= pwdata[hlfd_pkg::BYTE_W-1:0];
                end
                hlfd_pkg::REG_LENGTH_LIMIT: begin
                    cfg_reg.length_limit <= pwdata[hlfd_pkg::LEN_W-1:0];
                end
                hlfd_pkg::REG_POSITION_CAP: begin
                    cfg_reg.position_cap <= pwdata[hlfd_pkg::POS_W-1:0];
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            hlfd_pkg::REG_HEADER_FIRST: begin
                prdata = {24'd0, cfg_reg.header_first};
            end
            hlfd_pkg::REG_HEADER_SECOND: begin
                prdata = {24'd0, cfg_reg.header_second};
            end
            hlfd_pkg::REG_LENGTH_LIMIT: begin
                prdata = {16'd0, cfg_reg.length_limit};
            end
            hlfd_pkg::REG_POSITION_CAP: begin
                prdata = {27'd0, cfg_reg.position_cap};
            end
        endcase
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/header_length_frame_deframer_top.sv
// channel   dir  ports                                                transfer when
// s_        in   s_valid s_ready s_rx_byte                            s_valid & s_ready
// m_        out  m_valid m_ready m_frame_byte m_byte_pos m_last_byte  m_valid & m_ready
// apb       in   psel penable pwrite paddr pwdata prdata pready       write on access phase
//
// bytes that do not complete a frame are taken one per cycle
// a completing byte at position p starts a run of p+1 results, one per cycle
// shifted out of cell 0 of the byte chain; s_ready is low for that run
// a stalled m_ready holds the run; the output register frees s_ready on the last byte
// synchronous active-low reset, no clearing pass over the byte chain
// depends on hlfd_pkg, hlfd_cell, hlfd_cfg, assert_macros.svh
`include "assert_macros.svh"

module header_length_frame_deframer_top #(
    parameter int FRAME_BYTES = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [hlfd_pkg::BYTE_W-1:0]   s_rx_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [hlfd_pkg::BYTE_W-1:0]   m_frame_byte,
    output logic [hlfd_pkg::POS_W-1:0]    m_byte_pos,
    output logic                          m_last_byte,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hlfd_pkg::ADDR_W-1:0]   paddr,
    input  logic [hlfd_pkg::DATA_W-1:0]   pwdata,
    output logic [hlfd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int NCELL = (FRAME_BYTES < hlfd_pkg::POS_MAX) ? FRAME_BYTES
                                                              : hlfd_pkg::POS_MAX;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t                        state_reg;
    logic [hlfd_pkg::POS_W-1:0]    position_reg;
    logic [hlfd_pkg::POS_W-1:0]    position_next;
    logic [hlfd_pkg::LEN_W-1:0]    plen_reg;
    logic [hlfd_pkg::LEN_W-1:0]    plen_next;
    logic [hlfd_pkg::POS_W-1:0]    emit_cnt_reg;
    logic [hlfd_pkg::POS_W-1:0]    emit_last_reg;
    logic                          m_valid_reg;
    logic [hlfd_pkg::BYTE_W-1:0]   m_frame_byte_reg;
    logic [hlfd_pkg::POS_W-1:0]    m_byte_pos_reg;
    logic                          m_last_byte_reg;

    hlfd_pkg::cfg_t                cfg;
    logic                          s_accept;
    logic                          emit_start;
    logic                          load_out;
    logic [hlfd_pkg::LEN_W-1:0]    len_now;
    logic [hlfd_pkg::POS_W:0]      pos_inc;
    logic [hlfd_pkg::POS_W-1:0]    pos_off;
    logic [hlfd_pkg::BYTE_W-1:0]   cell_data [NCELL];

    hlfd_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid & s_ready;
    assign load_out = (state_reg == ST_EMIT) & (~m_valid_reg | m_ready);

    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        hlfd_pkg::cell_ctrl_t        ctrl;
        logic [hlfd_pkg::BYTE_W-1:0] nb_data;

        assign ctrl.wr_en    = s_accept & (position_reg == hlfd_pkg::POS_W'(i));
        assign ctrl.shift_en = load_out;

        if (i == NCELL - 1) begin : g_end
            assign nb_data = '0;
        end else begin : g_mid
            assign nb_data = cell_data[i+1];
        end

        hlfd_cell u_cell (
            .aclk     (aclk),
            .ctrl     (ctrl),
            .wr_data  (s_rx_byte),
            .shift_in (nb_data),
            .data     (cell_data[i])
        );
    end

    // frame position and length tracking
    always_comb begin
        len_now       = (position_reg == hlfd_pkg::LEN_HIGH_POS)
                        ? {s_rx_byte, cell_data[hlfd_pkg::LEN_LOW_POS]} : plen_reg;
        pos_inc       = {1'b0, position_reg} + 6'd1;
        pos_off       = position_reg - hlfd_pkg::LEN_HIGH_POS;
        emit_start    = 1'b0;
        plen_next     = plen_reg;
        position_next = position_reg;
        priority if (position_reg == '0) begin
            position_next = (s_rx_byte == cfg.header_first) ? 5'd1 : 5'd0;
        end else if (position_reg == 5'd1) begin
            position_next = (s_rx_byte == cfg.header_second) ? 5'd2 : 5'd0;
        end else if (position_reg == hlfd_pkg::LEN_HIGH_POS
                     && len_now >= cfg.length_limit) begin
            plen_next     = '0;
            position_next = '0;
        end else if (position_reg >= hlfd_pkg::LEN_HIGH_POS
                     && {11'd0, pos_off} == len_now) begin
            plen_next     = len_now;
            position_next = '0;
            emit_start    = 1'b1;
        end else begin
            plen_next     = len_now;
            position_next = (pos_inc > {1'b0, cfg.position_cap})
                            ? 5'd0 : pos_inc[hlfd_pkg::POS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            position_reg <= '0;
            plen_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_accept) begin
                position_reg <= position_next;
                plen_reg     <= plen_next;
                if (emit_start) begin
                    state_reg     <= ST_EMIT;
                    emit_cnt_reg  <= '0;
                    emit_last_reg <= position_reg;
                end
            end
            if (load_out) begin
                m_valid_reg      <= 1'b1;
                m_frame_byte_reg <= cell_data[0];
                m_byte_pos_reg   <= emit_cnt_reg;
                m_last_byte_reg  <= (emit_cnt_reg == emit_last_reg);
                emit_cnt_reg     <= emit_cnt_reg + 5'd1;
                if (emit_cnt_reg == emit_last_reg) begin
                    state_reg <= ST_IDLE;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_frame_byte = m_frame_byte_reg;
    assign m_byte_pos   = m_byte_pos_reg;
    assign m_last_byte  = m_last_byte_reg;

    `ASSERT_PROP(a_cnt_bound, aclk, aresetn,
        (state_reg == ST_EMIT) |-> (emit_cnt_reg <= emit_last_reg))
    `ASSERT_PROP(a_run_start, aclk, aresetn,
        $rose(state_reg == ST_EMIT) |->
            (emit_cnt_reg == '0 && emit_last_reg >= hlfd_pkg::LEN_HIGH_POS))
    `ASSERT_NEVER(a_no_accept_in_run, aclk, aresetn,
        (state_reg == ST_EMIT) && s_accept)
    `ASSERT_PROP(a_pos_follows, aclk, aresetn,
        (load_out && !$past(load_out) && state_reg == ST_EMIT && emit_cnt_reg != '0) |->
            (emit_cnt_reg == m_byte_pos_reg + 5'd1))

endmodule

FILE: bench/tb_top.sv
// self-checking bench for header_length_frame_deframer_top: a directed table of
// received bytes, then random frames over several register settings and idle mixes
// depends on hlfd_pkg and the deframer rtl; expected frames come from a local predictor

module tb_top;

    localparam int DIR_ROWS     = 28;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_BYTES  = 12;
    localparam int PHASES       = 6;
    localparam int PRESSURE_PH  = 4;
    localparam int STORE_DEPTH  = 32;
    localparam int LAST_POS     = 31;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_PAYLOAD  = 24;

    typedef struct packed {
        logic [hlfd_pkg::BYTE_W-1:0] frame_byte;
        logic [hlfd_pkg::POS_W-1:0]  byte_pos;
        logic                        last_byte;
    } frame_out_t;

    // header mismatches, a zero-length frame, an over-limit length, a one-byte payload
    localparam logic [hlfd_pkg::BYTE_W-1:0] DIR_RX [DIR_ROWS] = '{
        8'h00, 8'hAA, 8'hAA,
        8'hAA, 8'h55, 8'h00, 8'hFF, 8'h01, 8'hFE, 8'h00, 8'h00,
        8'hAA, 8'h55, 8'h11, 8'h22, 8'h33, 8'h44, 8'h32, 8'h00,
        8'hAA, 8'h55, 8'h5A, 8'hA5, 8'h0F, 8'hF0, 8'h01, 8'h00, 8'h80
    };
    localparam int DIR_RESULTS [DIR_ROWS] = '{
        0, 0, 0,
        0, 0, 0, 0, 0, 0, 0, 8,
        0, 0, 0, 0, 0, 0, 0, 0,
        -1, -1, -1, -1, -1, -1, -1, -1, -1
    };

    logic                          aclk;
    logic                          aresetn   = 1'b0;
    logic                          s_valid   = 1'b0;
    logic                          s_ready;
    logic [hlfd_pkg::BYTE_W-1:0]   s_rx_byte = '0;
    logic                          m_valid;
    logic                          m_ready   = 1'b0;
    logic [hlfd_pkg::BYTE_W-1:0]   m_frame_byte;
    logic [hlfd_pkg::POS_W-1:0]    m_byte_pos;
    logic                          m_last_byte;
    logic                          psel      = 1'b0;
    logic                          penable   = 1'b0;
    logic                          pwrite    = 1'b0;
    logic [hlfd_pkg::ADDR_W-1:0]   paddr     = '0;
    logic [hlfd_pkg::DATA_W-1:0]   pwdata    = '0;
    logic [hlfd_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    logic [hlfd_pkg::BYTE_W-1:0]   frame_mem [STORE_DEPTH];
    logic [hlfd_pkg::POS_W-1:0]    rx_pos     = '0;
    logic [hlfd_pkg::LEN_W-1:0]    pay_len    = '0;
    hlfd_pkg::cfg_t                cfg_shadow = '{hlfd_pkg::HEADER_FIRST_RST,
                                                  hlfd_pkg::HEADER_SECOND_RST,
                                                  hlfd_pkg::LENGTH_LIMIT_RST,
                                                  hlfd_pkg::POSITION_CAP_RST};
    frame_out_t                    frame_q [$];

    int fail_count        = 0;
    int last_step_results = 0;
    int bytes_sent        = 0;
    int s_idle_pct        = 0;
    int m_stall_pct       = 0;
    int hold_left         = 0;

    header_length_frame_deframer_top #(
        .FRAME_BYTES (STORE_DEPTH)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_byte (m_frame_byte),
        .m_byte_pos   (m_byte_pos),
        .m_last_byte  (m_last_byte),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // stores one byte, moves the frame position and queues a completed frame
    function automatic int deframe_byte(input logic [hlfd_pkg::BYTE_W-1:0] rx);
        logic [hlfd_pkg::POS_W-1:0] p;
        logic                       abandon;
        int                         n;
        p       = rx_pos;
        abandon = 1'b0;
        n       = 0;
        frame_mem[p] = rx;
        if (p == 0) begin
            rx_pos = (rx == cfg_shadow.header_first) ? hlfd_pkg::POS_W'(1) : '0;
        end else if (p == 1) begin
            rx_pos = (rx == cfg_shadow.header_second) ? hlfd_pkg::POS_W'(2) : '0;
        end else begin
            if (p == hlfd_pkg::LEN_HIGH_POS) begin
                pay_len = {frame_mem[hlfd_pkg::LEN_HIGH_POS], frame_mem[hlfd_pkg::LEN_LOW_POS]};
                if (pay_len >= cfg_shadow.length_limit) begin
                    pay_len = '0;
                    rx_pos  = '0;
                    abandon = 1'b1;
                end
            end
            if (!abandon) begin
                if (p >= hlfd_pkg::LEN_HIGH_POS &&
                    int'(p) - int'(hlfd_pkg::LEN_HIGH_POS) == int'(pay_len)) begin
                    rx_pos = '0;
                    for (int k = 0; k <= int'(p); k++)
                        frame_q.push_back(frame_out_t'{frame_mem[k], hlfd_pkg::POS_W'(k),
                                                       k == int'(p)});
                    n = int'(p) + 1;
                end else if (int'(p) + 1 > int'(cfg_shadow.position_cap) ||
                             int'(p) == LAST_POS) begin
                    rx_pos = '0;
                end else begin
                    rx_pos = p + 1'b1;
                end
            end
        end
        return n;
    endfunction

    always @(posedge aclk) begin
        frame_out_t exp_out;
        if (aresetn) begin
            if (s_valid && s_ready)
                last_step_results = deframe_byte(s_rx_byte);
            if (m_valid && m_ready) begin
                if (frame_q.size() == 0) begin
                    $error("unexpected result: frame_byte %0h byte_pos %0d last_byte %0b",
                           m_frame_byte, m_byte_pos, m_last_byte);
                    fail_count++;
                end else begin
                    exp_out = frame_q.pop_front();
                    if (m_frame_byte !== exp_out.frame_byte) begin
                        $error("frame_byte: expected %0h, got %0h",
                               exp_out.frame_byte, m_frame_byte);
                        fail_count++;
                    end
                    if (m_byte_pos !== exp_out.byte_pos) begin
                        $error("byte_pos: expected %0d, got %0d", exp_out.byte_pos, m_byte_pos);
                        fail_count++;
                    end
                    if (m_last_byte !== exp_out.last_byte) begin
                        $error("last_byte: expected %0b, got %0b",
                               exp_out.last_byte, m_last_byte);
                        fail_count++;
                    end
                end
            end
        end
    end

    // receiver side, with a long hold-off when requested
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= m_stall_pct);
        end
    end

    task automatic send_rx(input logic [hlfd_pkg::BYTE_W-1:0] rx);
        if (s_idle_pct > 0 && $urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < s_idle_pct);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= rx;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic reg_write(input hlfd_pkg::reg_idx_t idx,
                             input logic [hlfd_pkg::DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= hlfd_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            hlfd_pkg::REG_HEADER_FIRST:
                cfg_shadow.header_first  = val[hlfd_pkg::BYTE_W-1:0];
            hlfd_pkg::REG_HEADER_SECOND:
                cfg_shadow.header_second = val[hlfd_pkg::BYTE_W-1:0];
            hlfd_pkg::REG_LENGTH_LIMIT:
                cfg_shadow.length_limit  = val[hlfd_pkg::LEN_W-1:0];
            hlfd_pkg::REG_POSITION_CAP:
                cfg_shadow.position_cap  = val[hlfd_pkg::POS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (frame_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // mostly well-formed frames with random content, some noise and broken headers
    task automatic send_frame();
        int                         reach;
        int                         len_sel;
        int                         n_pay;
        logic [hlfd_pkg::LEN_W-1:0] len;
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(1, 3)) send_rx(hlfd_pkg::BYTE_W'($urandom));
        send_rx(($urandom_range(99) < 85) ? cfg_shadow.header_first
                                          : hlfd_pkg::BYTE_W'($urandom));
        send_rx(($urandom_range(99) < 85) ? cfg_shadow.header_second
                                          : hlfd_pkg::BYTE_W'($urandom));
        repeat (4) send_rx(hlfd_pkg::BYTE_W'($urandom));
        reach = int'(cfg_shadow.position_cap) - int'(hlfd_pkg::LEN_HIGH_POS);
        if (int'(cfg_shadow.length_limit) - 1 < reach)
            reach = int'(cfg_shadow.length_limit) - 1;
        len_sel = $urandom_range(99);
        if (len_sel < 75 && reach >= 0)
            len = hlfd_pkg::LEN_W'($urandom_range(reach));
        else if (len_sel < 90)
            len = hlfd_pkg::LEN_W'($urandom);
        else
            len = hlfd_pkg::LEN_W'($urandom_range(40));
        send_rx(len[7:0]);
        send_rx(len[15:8]);
        n_pay = (int'(len) > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(len);
        repeat (n_pay) send_rx(hlfd_pkg::BYTE_W'($urandom));
    endtask

    initial begin
        int phase_start;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            send_rx(DIR_RX[i]);
            if (DIR_RESULTS[i] >= 0 && last_step_results != DIR_RESULTS[i]) begin
                $error("result count: expected %0d, got %0d", DIR_RESULTS[i], last_step_results);
                fail_count++;
            end
        end
        s_valid <= 1'b0;
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    reg_write(hlfd_pkg::REG_HEADER_FIRST,
                              hlfd_pkg::DATA_W'(hlfd_pkg::HEADER_FIRST_RST));
                    reg_write(hlfd_pkg::REG_HEADER_SECOND,
                              hlfd_pkg::DATA_W'(hlfd_pkg::HEADER_SECOND_RST));
                    s_idle_pct  = 0;
                    m_stall_pct = 0;
                end
                1: begin
                    reg_write(hlfd_pkg::REG_HEADER_FIRST, 32'h00);
                    reg_write(hlfd_pkg::REG_HEADER_SECOND, 32'hFF);
                    reg_write(hlfd_pkg::REG_LENGTH_LIMIT, 32'hFFFF);
                    reg_write(hlfd_pkg::REG_POSITION_CAP, 32'd31);
                    s_idle_pct  = 63;
                    m_stall_pct = 0;
                end
                2: begin
                    reg_write(hlfd_pkg::REG_HEADER_FIRST, 32'hFF);
                    reg_write(hlfd_pkg::REG_HEADER_SECOND, 32'h00);
                    reg_write(hlfd_pkg::REG_LENGTH_LIMIT, 32'd1000);
                    reg_write(hlfd_pkg::REG_POSITION_CAP, 32'd8);
                    s_idle_pct  = 0;
                    m_stall_pct = 63;
                end
                3: begin
                    reg_write(hlfd_pkg::REG_HEADER_FIRST,
                              hlfd_pkg::DATA_W'($urandom_range(255)));
                    reg_write(hlfd_pkg::REG_HEADER_SECOND,
                              hlfd_pkg::DATA_W'($urandom_range(255)));
                    reg_write(hlfd_pkg::REG_LENGTH_LIMIT,
                              hlfd_pkg::DATA_W'($urandom_range(1, 60)));
                    reg_write(hlfd_pkg::REG_POSITION_CAP,
                              hlfd_pkg::DATA_W'($urandom_range(8, 31)));
                    s_idle_pct  = 30;
                    m_stall_pct = 30;
                end
                4: begin
                    reg_write(hlfd_pkg::REG_HEADER_FIRST, 32'hAA);
                    reg_write(hlfd_pkg::REG_HEADER_SECOND, 32'h55);
                    reg_write(hlfd_pkg::REG_LENGTH_LIMIT, 32'd30);
                    reg_write(hlfd_pkg::REG_POSITION_CAP, 32'd31);
                    s_idle_pct  = 0;
                    m_stall_pct = 0;
                    hold_left   = HOLD_CYCLES;
                end
                default: begin
                    reg_write(hlfd_pkg::REG_HEADER_FIRST,
                              hlfd_pkg::DATA_W'($urandom_range(255)));
                    reg_write(hlfd_pkg::REG_HEADER_SECOND,
                              hlfd_pkg::DATA_W'($urandom_range(255)));
                    reg_write(hlfd_pkg::REG_LENGTH_LIMIT, 32'd0);
                    reg_write(hlfd_pkg::REG_POSITION_CAP,
                              hlfd_pkg::DATA_W'($urandom_range(8, 31)));
                    s_idle_pct  = 30;
                    m_stall_pct = 30;
                end
            endcase
            phase_start = bytes_sent;
            // the pressure phase keeps offering bytes for the whole hold-off
            while (bytes_sent - phase_start < PHASE_BYTES ||
                   (ph == PRESSURE_PH && hold_left > 0))
                send_frame();
            s_valid <= 1'b0;
            wait_drained();
        end

        if (fail_count == 0 && frame_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
